@@ sv/fusf_pkg.sv @@
// Shared types and constants for the firmware-update session receiver.
package fusf_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 21;
    localparam int TMO_W   = 16;
    localparam int IDLE_W  = 17;
    localparam int LEN_W   = 8;
    localparam int OP_W    = 3;
    localparam int PHASE_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_DATA  = 3'd2;
    localparam logic [OP_W-1:0] OP_END   = 3'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RECV     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_VERIFY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COMMIT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_ROLLBACK = 3'd4;
    localparam logic [PHASE_W-1:0] PH_JUMP     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_APP_BASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [ADDR_W-1:0] APP_BASE_RST = 32'd0;
    localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 21'd65536;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 16'd5000;
    localparam logic [IDLE_W-1:0] IDLE_MAX     = '1;

    typedef struct packed {
        logic [ADDR_W-1:0] app_base;
        logic [SIZE_W-1:0] max_size;
        logic [TMO_W-1:0]  timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [IDLE_W-1:0]  idle_ticks;
        logic [SIZE_W-1:0]  bytes_received;
        logic               finished;
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [LEN_W-1:0] payload_length;
        logic             verify_pass;
    } in_item_t;

    typedef struct packed {
        logic               ack;
        logic               write_valid;
        logic [ADDR_W-1:0]  write_address;
        logic [LEN_W-1:0]   write_length;
        logic [PHASE_W-1:0] phase_now;
        logic [SIZE_W-1:0]  image_size;
        logic               mark_valid;
        logic               do_rollback;
        logic               jump_app;
        logic               done_res;
    } out_item_t;

endpackage

@@ sv/fusf_if.sv @@
// Command and result channel interfaces (valid/ready handshake).
interface fusf_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [fusf_pkg::OP_W-1:0]     opcode;
    logic [fusf_pkg::LEN_W-1:0]    payload_length;
    logic                          verify_pass;

    modport source (output valid, opcode, payload_length, verify_pass, input ready);
    modport sink   (input valid, opcode, payload_length, verify_pass, output ready);
endinterface

interface fusf_res_if;
    logic                           valid;
    logic                           ready;
    logic                           ack;
    logic                           write_valid;
    logic [fusf_pkg::ADDR_W-1:0]    write_address;
    logic [fusf_pkg::LEN_W-1:0]     write_length;
    logic [fusf_pkg::PHASE_W-1:0]   phase_now;
    logic [fusf_pkg::SIZE_W-1:0]    image_size;
    logic                           mark_valid;
    logic                           do_rollback;
    logic                           jump_app;
    logic                           done_res;

    modport source (output valid, ack, write_valid, write_address, write_length, phase_now,
                    image_size, mark_valid, do_rollback, jump_app, done_res,
                    input ready);
    modport sink   (input valid, ack, write_valid, write_address, write_length, phase_now,
                    image_size, mark_valid, do_rollback, jump_app, done_res,
                    output ready);
endinterface

@@ sv/fusf_cfg.sv @@
// Configuration register file: app base, size limit, idle timeout.
module fusf_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fusf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fusf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fusf_pkg::cfg_t                     cfg
);

    fusf_pkg::cfg_t cfg_reg;
    fusf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fusf_pkg::REG_APP_BASE:
                begin
                    cfg_next.app_base = cfg_data[fusf_pkg::ADDR_W-1:0];
                end
                fusf_pkg::REG_MAX_SIZE:
                begin
                    cfg_next.max_size = cfg_data[fusf_pkg::SIZE_W-1:0];
                end
                fusf_pkg::REG_TIMEOUT_TICKS:
                begin
                    cfg_next.timeout_ticks = cfg_data[fusf_pkg::TMO_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.app_base      <= fusf_pkg::APP_BASE_RST;
            cfg_reg.max_size      <= fusf_pkg::MAX_SIZE_RST;
            cfg_reg.timeout_ticks <= fusf_pkg::TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/fusf_step.sv @@
// Session step logic: next phase, counters and result for one item.
module fusf_step
(
    input  fusf_pkg::cfg_t      cfg,
    input  fusf_pkg::state_t    st,
    input  fusf_pkg::in_item_t  item,
    output fusf_pkg::state_t    st_next,
    output fusf_pkg::out_item_t res
);

    logic [fusf_pkg::IDLE_W-1:0] idle_inc;
    logic [fusf_pkg::SIZE_W:0]   size_sum;

    assign idle_inc = (st.idle_ticks == fusf_pkg::IDLE_MAX) ? st.idle_ticks
                                                             : st.idle_ticks + 1'b1;
    assign size_sum = {1'b0, st.bytes_received}
                    + {{(fusf_pkg::SIZE_W + 1 - fusf_pkg::LEN_W){1'b0}}, item.payload_length};

    always_comb
    begin
        st_next = st;
        res     = '0;
        if (item.opcode == fusf_pkg::OP_TICK)
        begin
            st_next.idle_ticks = idle_inc;
            case (st.phase)
                fusf_pkg::PH_RECV:
                begin
                    if (idle_inc > {1'b0, cfg.timeout_ticks})
                    begin
                        st_next.phase = fusf_pkg::PH_ROLLBACK;
                    end
                end
                fusf_pkg::PH_VERIFY:
                begin
                    st_next.phase = item.verify_pass ? fusf_pkg::PH_COMMIT
                                                     : fusf_pkg::PH_ROLLBACK;
                end
                fusf_pkg::PH_COMMIT:
                begin
                    res.mark_valid = 1'b1;
                    st_next.phase  = fusf_pkg::PH_JUMP;
                end
                fusf_pkg::PH_ROLLBACK:
                begin
                    res.do_rollback = 1'b1;
                    st_next.phase   = fusf_pkg::PH_JUMP;
                end
                fusf_pkg::PH_JUMP:
                begin
                    st_next.finished = 1'b1;
                    res.jump_app     = 1'b1;
                end
                default:
                begin
                    st_next.phase = st.phase;
                end
            endcase
        end
        else
        begin
            st_next.idle_ticks = '0;
            case (item.opcode)
                fusf_pkg::OP_START:
                begin
                    st_next.bytes_received = '0;
                    st_next.phase          = fusf_pkg::PH_RECV;
                    res.ack                = 1'b1;
                end
                fusf_pkg::OP_DATA:
                begin
                    if (st.phase == fusf_pkg::PH_RECV)
                    begin
                        if (size_sum > {1'b0, cfg.max_size})
                        begin
                            st_next.phase = fusf_pkg::PH_ROLLBACK;
                        end
                        else
                        begin
                            res.write_valid   = 1'b1;
                            res.write_address = cfg.app_base
                                + {{(fusf_pkg::ADDR_W - fusf_pkg::SIZE_W){1'b0}},
                                   st.bytes_received};
                            res.write_length  = item.payload_length;
                            st_next.bytes_received = size_sum[fusf_pkg::SIZE_W-1:0];
                            res.ack           = 1'b1;
                        end
                    end
                end
                fusf_pkg::OP_END:
                begin
                    st_next.phase = fusf_pkg::PH_VERIFY;
                    res.ack       = 1'b1;
                end
                default:
                begin
                    st_next.phase = st.phase;
                end
            endcase
        end
        res.phase_now  = st_next.phase;
        res.image_size = st_next.bytes_received;
        res.done_res   = st_next.finished;
    end

endmodule

@@ sv/firmware_update_session_fsm.sv @@
// Firmware-update session receiver top level: item registers, session state, result register.
// The result is registered: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless stalled; the session state loop is one registered step.
// A full result register stalls the input register; the command side still takes an item
// while the input register drains into a free or draining result register.
// Reset (rst_n, async low): phase idle, counters and finished flag cleared, config to defaults.
module firmware_update_session_fsm
(
    input  logic                            clk,
    input  logic                            rst_n,
    fusf_cmd_if.sink                        cmd,
    fusf_res_if.source                      result,
    input  logic                            cfg_we,
    input  logic [fusf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fusf_pkg::CFG_DATA_W-1:0] cfg_data
);

    fusf_pkg::cfg_t      cfg;
    fusf_pkg::state_t    st_reg;
    fusf_pkg::state_t    st_next;
    fusf_pkg::in_item_t  item_reg;
    fusf_pkg::out_item_t res_reg;
    fusf_pkg::out_item_t res_next;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                take;

    fusf_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fusf_step u_step
    (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // step the session when the held item can move into the result register
    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign take      = cmd.valid && cmd.ready;
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg.phase          <= fusf_pkg::PH_IDLE;
            st_reg.idle_ticks     <= '0;
            st_reg.bytes_received <= '0;
            st_reg.finished       <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.opcode         <= cmd.opcode;
            item_reg.payload_length <= cmd.payload_length;
            item_reg.verify_pass    <= cmd.verify_pass;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.ack           = res_reg.ack;
    assign result.write_valid   = res_reg.write_valid;
    assign result.write_address = res_reg.write_address;
    assign result.write_length  = res_reg.write_length;
    assign result.phase_now     = res_reg.phase_now;
    assign result.image_size    = res_reg.image_size;
    assign result.mark_valid    = res_reg.mark_valid;
    assign result.do_rollback   = res_reg.do_rollback;
    assign result.jump_app      = res_reg.jump_app;
    assign result.done_res      = res_reg.done_res;

    a_write_acked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.write_valid) |->
            (res_reg.ack && res_reg.phase_now == fusf_pkg::PH_RECV))
        else $error("flash write without ack or outside receiving");

    a_pulse_to_jump: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_reg.mark_valid || res_reg.do_rollback || res_reg.jump_app)) |->
            (res_reg.phase_now == fusf_pkg::PH_JUMP))
        else $error("phase action pulse not followed by jump phase");

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.finished |=> st_reg.finished)
        else $error("finished flag cleared");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (in_valid_reg && out_valid_reg && !result.ready))
        else $error("command side stalled with room in the pipeline");

    a_size_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.opcode == fusf_pkg::OP_DATA && res_next.write_valid) |->
            (res_next.image_size <= cfg.max_size))
        else $error("image size grew past the limit");

endmodule
